### hw/rtl/cnv_pkg.sv
// Shared constants and types of the normalised 2-D convolution block.
`timescale 1ns / 1ps
package cnv_pkg;

    localparam int DEF_MAX_KERNEL  = 3;
    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int COEF_SIDE  = 3;
    localparam int COEF_BITS  = 16;
    localparam int KSUM_BITS  = COEF_BITS + 4;
    localparam int OUT_BITS   = 35;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 48;
    localparam int KSIZE_BITS = 2;
    localparam int DIM_BITS   = 11;

    localparam logic [KSIZE_BITS-1:0]    RST_KSIZE  = 2'd3;
    localparam logic [DIM_BITS-1:0]      RST_WIDTH  = 11'd1024;
    localparam logic [DIM_BITS-1:0]      RST_HEIGHT = 11'd1024;
    localparam logic [CFG_DATA_BITS-1:0] RST_KROW_MID = 48'h0000_0001_0000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_KERNEL_SIZE   = 3'd0,
        CFG_IMAGE_WIDTH   = 3'd1,
        CFG_IMAGE_HEIGHT  = 3'd2,
        CFG_KROW_TOP      = 3'd3,
        CFG_KROW_MIDDLE   = 3'd4,
        CFG_KROW_BOTTOM   = 3'd5
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MAC,
        S_PREP,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

endpackage

### hw/rtl/cnv_line.sv
// One line store: a row of samples, read and written at the column position.
`timescale 1ns / 1ps
module cnv_line #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/cnv_cell.sv
// One window cell: a column of samples that moves to the left neighbour.
`timescale 1ns / 1ps
module cnv_cell #(
    parameter int N  = 3,
    parameter int DW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_shift,
    input  logic [N-1:0][DW-1:0] i_col,
    output logic [N-1:0][DW-1:0] o_col
);

    logic [N-1:0][DW-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

### hw/rtl/normalized_2d_convolution.sv
// Top level: raster counters, line stores, window cell chain, MAC and divider.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_sample
//  result    out        o_valid / i_stall    o_filtered_value, o_zero_divisor,
//                                            o_last_of_image
//  config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// A sample with no result passes from idle through load and back to idle; one with a result
// also runs the k*k taps through the shared multiplier, prepares, runs the bit-serial
// divider (SAMPLE_BITS+20 quotient bits), fixes the sign and outputs; a zero kernel sum
// goes from prepare straight to output. Synchronous active-low reset clears counters,
// window and output valid; line stores hold garbage until written. A stalled result
// holds in the output register; the block waits before writing over it.
`timescale 1ns / 1ps
module normalized_2d_convolution #(
    parameter int MAX_KERNEL  = cnv_pkg::DEF_MAX_KERNEL,
    parameter int MAX_WIDTH   = cnv_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = cnv_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = cnv_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [SAMPLE_BITS-1:0]          i_sample,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [cnv_pkg::OUT_BITS-1:0]    o_filtered_value,
    output logic                                   o_zero_divisor,
    output logic                                   o_last_of_image,
    input  logic                                   i_cfg_we,
    input  logic [cnv_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [cnv_pkg::CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XW    = (CW + 1 > cnv_pkg::DIM_BITS) ? CW + 1 : cnv_pkg::DIM_BITS;
    localparam int YW    = (RW + 1 > cnv_pkg::DIM_BITS) ? RW + 1 : cnv_pkg::DIM_BITS;
    localparam int KMAXV = (MAX_KERNEL < cnv_pkg::COEF_SIDE) ? MAX_KERNEL
                                                             : cnv_pkg::COEF_SIDE;
    localparam int KIW   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int PW    = SAMPLE_BITS + cnv_pkg::COEF_BITS;
    localparam int ACC_W = PW + 4;
    localparam int KSW   = cnv_pkg::KSUM_BITS;
    localparam int DCW   = $clog2(ACC_W + 1);

    // configuration
    logic [cnv_pkg::KSIZE_BITS-1:0]    r_ksize;
    logic [cnv_pkg::DIM_BITS-1:0]      r_width;
    logic [cnv_pkg::DIM_BITS-1:0]      r_height;
    logic [cnv_pkg::CFG_DATA_BITS-1:0] r_krow [cnv_pkg::COEF_SIDE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize  <= cnv_pkg::RST_KSIZE;
            r_width  <= cnv_pkg::RST_WIDTH;
            r_height <= cnv_pkg::RST_HEIGHT;
            r_krow[0] <= '0;
            r_krow[1] <= cnv_pkg::RST_KROW_MID;
            r_krow[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (cnv_pkg::t_cfg_index'(i_cfg_index))
                cnv_pkg::CFG_KERNEL_SIZE:
                    r_ksize <= i_cfg_data[cnv_pkg::KSIZE_BITS-1:0];
                cnv_pkg::CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[cnv_pkg::DIM_BITS-1:0];
                cnv_pkg::CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[cnv_pkg::DIM_BITS-1:0];
                cnv_pkg::CFG_KROW_TOP:     r_krow[0] <= i_cfg_data;
                cnv_pkg::CFG_KROW_MIDDLE:  r_krow[1] <= i_cfg_data;
                cnv_pkg::CFG_KROW_BOTTOM:  r_krow[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped settings
    logic [XW-1:0] w_wext, w_w;
    logic [YW-1:0] w_hext, w_h;
    logic [cnv_pkg::KSIZE_BITS-1:0] w_k;

    always_comb begin
        w_wext = XW'(r_width);
        w_hext = YW'(r_height);
        if (w_wext == '0) w_w = XW'(1);
        else if (w_wext > XW'(MAX_WIDTH)) w_w = XW'(MAX_WIDTH);
        else w_w = w_wext;
        if (w_hext == '0) w_h = YW'(1);
        else if (w_hext > YW'(MAX_HEIGHT)) w_h = YW'(MAX_HEIGHT);
        else w_h = w_hext;
        if (r_ksize == '0) w_k = cnv_pkg::KSIZE_BITS'(1);
        else if (int'(r_ksize) > KMAXV) w_k = cnv_pkg::KSIZE_BITS'(KMAXV);
        else w_k = r_ksize;
    end

    // control
    cnv_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_addr;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic r_emit, r_last;
    logic [1:0] r_p, r_t;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [KSW-1:0]   r_ksum;
    logic [ACC_W-1:0] r_quo;
    logic [KSW-1:0]   r_rem, r_dmag;
    logic             r_neg, r_zero;
    logic [DCW-1:0]   r_cnt;
    logic signed [cnv_pkg::OUT_BITS-1:0] r_res;
    logic signed [cnv_pkg::OUT_BITS-1:0] r_o_value;
    logic r_o_zero, r_o_last, r_o_valid;

    logic w_accept, w_row_end, w_img_end, w_emit, w_mac_last, w_out_free, w_shift;

    assign w_accept  = i_valid && !o_stall;
    assign w_row_end = (XW'(r_col) + XW'(1)) >= w_w;
    assign w_img_end = w_row_end && ((YW'(r_row) + YW'(1)) >= w_h);
    assign w_emit    = ((YW'(r_row) + YW'(1)) >= YW'(w_k))
                    && ((XW'(r_col) + XW'(1)) >= XW'(w_k));
    assign w_mac_last = (r_p == w_k - 2'd1) && (r_t == w_k - 2'd1);
    assign w_out_free = !r_o_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cnv_pkg::S_IDLE: if (w_accept) n_state = cnv_pkg::S_LOAD;
            cnv_pkg::S_LOAD: n_state = r_emit ? cnv_pkg::S_MAC : cnv_pkg::S_IDLE;
            cnv_pkg::S_MAC:  if (w_mac_last) n_state = cnv_pkg::S_PREP;
            cnv_pkg::S_PREP: n_state = (r_ksum == '0) ? cnv_pkg::S_OUT : cnv_pkg::S_DIV;
            cnv_pkg::S_DIV:  if (r_cnt == DCW'(1)) n_state = cnv_pkg::S_FIN;
            cnv_pkg::S_FIN:  n_state = cnv_pkg::S_OUT;
            cnv_pkg::S_OUT:  if (w_out_free) n_state = cnv_pkg::S_IDLE;
            default:         n_state = cnv_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall = (r_state != cnv_pkg::S_IDLE);
        w_shift = (r_state == cnv_pkg::S_LOAD);
    end

    // line stores and window cells
    logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] w_newcol;
    logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] w_cellin  [MAX_KERNEL];
    logic [MAX_KERNEL-1:0][SAMPLE_BITS-1:0] w_cellout [MAX_KERNEL];

    assign w_newcol[0] = r_sample;

    genvar gd, gt;
    generate
        for (gd = 1; gd < MAX_KERNEL; gd++) begin : g_line
            logic [SAMPLE_BITS-1:0] w_rd;
            cnv_line #(
                .DEPTH (MAX_WIDTH),
                .AW    (CW),
                .DW    (SAMPLE_BITS)
            ) u_line (
                .i_clk     (i_clk),
                .i_rd_en   (w_accept),
                .i_rd_addr (r_col),
                .o_rd_data (w_rd),
                .i_wr_en   (w_shift),
                .i_wr_addr (r_addr),
                .i_wr_data (w_newcol[gd-1])
            );
            assign w_newcol[gd] = w_rd;
        end

        for (gt = 0; gt < MAX_KERNEL; gt++) begin : g_cell
            if (gt == MAX_KERNEL - 1) begin : g_head
                for (gd = 0; gd < MAX_KERNEL; gd++) begin : g_rev
                    assign w_cellin[gt][gd] = w_newcol[MAX_KERNEL-1-gd];
                end
            end else begin : g_body
                assign w_cellin[gt] = w_cellout[gt+1];
            end
            cnv_cell #(
                .N  (MAX_KERNEL),
                .DW (SAMPLE_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_col   (w_cellin[gt]),
                .o_col   (w_cellout[gt])
            );
        end
    endgenerate

    // tap selection for the multiply-accumulate
    logic [KIW-1:0] w_wrow, w_wcol;
    logic signed [SAMPLE_BITS-1:0] w_tap;
    logic signed [cnv_pkg::COEF_BITS-1:0] w_coef;
    logic signed [PW-1:0] w_prod;
    logic [KSW:0] w_trial;
    logic w_ge;
    logic signed [ACC_W:0] w_sq;

    always_comb begin
        w_wrow = KIW'(MAX_KERNEL - int'(w_k) + int'(r_p));
        w_wcol = KIW'(MAX_KERNEL - int'(w_k) + int'(r_t));
        w_tap  = w_cellout[w_wcol][w_wrow];
        w_coef = r_krow[r_p][r_t*cnv_pkg::COEF_BITS +: cnv_pkg::COEF_BITS];
        w_prod = PW'(w_tap) * PW'(w_coef);
        w_trial = {r_rem, r_quo[ACC_W-1]};
        w_ge    = w_trial >= {1'b0, r_dmag};
        w_sq    = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cnv_pkg::S_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (w_row_end) begin
                    r_col <= '0;
                    r_row <= w_img_end ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (r_state == cnv_pkg::S_OUT && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_sample;
            r_addr   <= r_col;
            r_emit   <= w_emit;
            r_last   <= w_img_end;
        end
        unique case (r_state)
            cnv_pkg::S_LOAD: begin
                r_p    <= '0;
                r_t    <= '0;
                r_acc  <= '0;
                r_ksum <= '0;
            end
            cnv_pkg::S_MAC: begin
                r_acc  <= r_acc + ACC_W'(w_prod);
                r_ksum <= r_ksum + KSW'(w_coef);
                if (r_t == w_k - 2'd1) begin
                    r_t <= '0;
                    r_p <= r_p + 2'd1;
                end else begin
                    r_t <= r_t + 2'd1;
                end
            end
            cnv_pkg::S_PREP: begin
                r_zero <= (r_ksum == '0);
                r_res  <= '0;
                r_quo  <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
                r_dmag <= r_ksum[KSW-1] ? KSW'(-r_ksum) : KSW'(r_ksum);
                r_neg  <= r_acc[ACC_W-1] ^ r_ksum[KSW-1];
                r_rem  <= '0;
                r_cnt  <= DCW'(ACC_W);
            end
            cnv_pkg::S_DIV: begin
                // one quotient bit per cycle, restoring
                r_rem <= w_ge ? KSW'(w_trial - {1'b0, r_dmag}) : KSW'(w_trial);
                r_quo <= {r_quo[ACC_W-2:0], w_ge};
                r_cnt <= r_cnt - DCW'(1);
            end
            cnv_pkg::S_FIN: begin
                r_res <= cnv_pkg::OUT_BITS'(w_sq);
            end
            cnv_pkg::S_OUT: begin
                if (w_out_free) begin
                    r_o_value <= r_res;
                    r_o_zero  <= r_zero;
                    r_o_last  <= r_last;
                end
            end
            default: ;
        endcase
    end

    assign o_valid          = r_o_valid;
    assign o_filtered_value = r_o_value;
    assign o_zero_divisor   = r_o_zero;
    assign o_last_of_image  = r_o_last;

endmodule

### bench/normalized_2d_convolution_test.sv
// Self-checking bench for the normalised 2-D convolution block, with its own prediction.
`timescale 1ns / 1ps
module normalized_2d_convolution_test;

    localparam int  LIMIT = 3000000;
    localparam int  DRAIN = 120;

    typedef struct packed {
        logic signed [cnv_pkg::OUT_BITS-1:0] value;
        logic                                zdiv;
        logic                                last;
    } t_filt;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic signed [15:0] i_sample = '0;
    logic i_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [cnv_pkg::CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [cnv_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic o_stall, o_valid, o_zero_divisor, o_last_of_image;
    logic signed [cnv_pkg::OUT_BITS-1:0] o_filtered_value;

    normalized_2d_convolution uut (.*);

    // shadow of the block's registers and state
    logic [1:0]  sh_ksize;
    logic [10:0] sh_width, sh_height;
    logic [47:0] sh_krow [3];
    logic signed [15:0] line_mem [2][1024];
    logic signed [15:0] win [3][3];
    int col_cnt, row_cnt;

    logic signed [15:0] samples_due[$];
    t_filt filt_due[$];
    int errors = 0, n_in = 0, n_out = 0, n_zero = 0, n_last = 0, cycles = 0;
    bit calm = 0, hold_req = 0, hold_done = 0;
    int hold_left = 0;
    bit go;

    initial forever #4 i_clk = ~i_clk;

    function automatic int clampv(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [47:0] pack3(int c0, int c1, int c2);
        logic [15:0] a, b, d;
        a = 16'(c0); b = 16'(c1); d = 16'(c2);
        return {d, b, a};
    endfunction

    task automatic convolve_sample(input logic signed [15:0] s);
        int k, w, h, c, r, base;
        longint acc, ksum, q, cf;
        logic signed [15:0] col [3];
        bit row_end, img_end;
        t_filt e;
        k = clampv(sh_ksize, 3);
        w = clampv(sh_width, 1024);
        h = clampv(sh_height, 1024);
        c = col_cnt; r = row_cnt;
        if (c >= 1024) c = 1023;
        col[0] = s; col[1] = line_mem[0][c]; col[2] = line_mem[1][c];
        line_mem[1][c] = line_mem[0][c];
        line_mem[0][c] = s;
        for (int p = 0; p < 3; p++) begin
            win[p][0] = win[p][1];
            win[p][1] = win[p][2];
            win[p][2] = col[2-p];
        end
        row_end = (c + 1 >= w);
        img_end = row_end && (r + 1 >= h);
        if (r + 1 >= k && c + 1 >= k) begin
            acc = 0; ksum = 0; q = 0;
            base = 3 - k;
            for (int p = 0; p < k; p++)
                for (int t = 0; t < k; t++) begin
                    cf = longint'($signed(sh_krow[p][16*t +: 16]));
                    ksum += cf;
                    acc += longint'(win[base+p][base+t]) * cf;
                end
            if (ksum != 0) q = acc / ksum;
            e.value = q[cnv_pkg::OUT_BITS-1:0];
            e.zdiv = (ksum == 0);
            e.last = img_end;
            filt_due.push_back(e);
        end
        if (row_end) begin
            col_cnt = 0;
            row_cnt = img_end ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    // driver: present the oldest pending sample, hold it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                convolve_sample(i_sample);
                void'(samples_due.pop_front());
                n_in++;
            end
            go = (i_valid && o_stall) ||
                 (samples_due.size() > 0 && (calm || $urandom_range(99) >= 26));
            if (go && samples_due.size() > 0) begin
                i_valid  <= 1'b1;
                i_sample <= samples_due[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: check each result transfer and drive the stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (filt_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %0d", o_filtered_value);
            end else begin
                if (filt_due[0].value !== o_filtered_value ||
                    filt_due[0].zdiv !== o_zero_divisor ||
                    filt_due[0].last !== o_last_of_image) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%b/%b got %0d/%b/%b",
                                 filt_due[0].value, filt_due[0].zdiv, filt_due[0].last,
                                 o_filtered_value, o_zero_divisor, o_last_of_image);
                end
                n_zero += o_zero_divisor;
                n_last += o_last_of_image;
                void'(filt_due.pop_front());
            end
            n_out++;
        end
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 26);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** normalized_2d_convolution: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(input cnv_pkg::t_cfg_index idx, input logic [47:0] d);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        case (idx)
            cnv_pkg::CFG_KERNEL_SIZE:  sh_ksize = d[1:0];
            cnv_pkg::CFG_IMAGE_WIDTH:  sh_width = d[10:0];
            cnv_pkg::CFG_IMAGE_HEIGHT: sh_height = d[10:0];
            cnv_pkg::CFG_KROW_TOP:     sh_krow[0] = d;
            cnv_pkg::CFG_KROW_MIDDLE:  sh_krow[1] = d;
            cnv_pkg::CFG_KROW_BOTTOM:  sh_krow[2] = d;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(input int ks, input int w, input int h,
                         input logic [47:0] t, input logic [47:0] m, input logic [47:0] b);
        write_reg(cnv_pkg::CFG_KERNEL_SIZE, 48'(ks));
        write_reg(cnv_pkg::CFG_IMAGE_WIDTH, 48'(w));
        write_reg(cnv_pkg::CFG_IMAGE_HEIGHT, 48'(h));
        write_reg(cnv_pkg::CFG_KROW_TOP, t);
        write_reg(cnv_pkg::CFG_KROW_MIDDLE, m);
        write_reg(cnv_pkg::CFG_KROW_BOTTOM, b);
    endtask

    task automatic settle();
        while (samples_due.size() > 0 || filt_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rand_row(int mode);
        case (mode)
            0: return 48'({$urandom, $urandom});
            1: return pack3($urandom_range(8) - 4, $urandom_range(8) - 4,
                            $urandom_range(8) - 4);
            default: return '0;
        endcase
    endfunction

    task automatic directed();
        // extremes through a full 3x3 window
        setup(3, 3, 3, pack3(32767, -32768, 1), pack3(-1, 32767, -32768),
              pack3(2, -3, 32767));
        for (int i = 0; i < 9; i++)
            samples_due.push_back(i[0] ? 16'sh8000 : 16'sh7FFF);
        settle();
        // zero kernel sum, single-tap kernel
        setup(1, 2, 2, 48'h0, 48'h0, 48'h0);
        samples_due.push_back(16'sh8000); samples_due.push_back(16'sh7FFF);
        samples_due.push_back(16'sh0001); samples_due.push_back(16'shFFFF);
        settle();
        // negative kernel sum, truncation toward zero
        setup(2, 3, 2, pack3(-1, -2, 0), pack3(1, -1, 0), 48'h0);
        for (int i = 0; i < 6; i++) samples_due.push_back(16'(i * 5 - 13));
        settle();
        // kernel larger than the image: nothing comes out
        setup(3, 2, 2, pack3(1, 1, 1), pack3(1, 1, 1), pack3(1, 1, 1));
        for (int i = 0; i < 4; i++) samples_due.push_back(rand_sample());
        settle();
    endtask

    initial begin
        int sent, w, h, md, phase;
        sh_ksize = cnv_pkg::RST_KSIZE;
        sh_width = cnv_pkg::RST_WIDTH;
        sh_height = cnv_pkg::RST_HEIGHT;
        sh_krow[0] = '0; sh_krow[1] = cnv_pkg::RST_KROW_MID; sh_krow[2] = '0;
        col_cnt = 0; row_cnt = 0;
        foreach (win[p, t]) win[p][t] = '0;
        foreach (line_mem[d, c]) line_mem[d][c] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        directed();

        sent = 0; phase = 0;
        while (sent < 620) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(40, 14) : $urandom_range(12);
            h = $urandom_range(8);
            md = $urandom_range(3);
            // a single-tap kernel in the held-off image keeps results flowing
            setup((phase == 5) ? 1 : $urandom_range(3), w, h,
                  rand_row(md), rand_row(md), rand_row(md));
            calm = (phase == 3);
            for (int i = 0; i < clampv(w, 1024) * clampv(h, 1024); i++)
                samples_due.push_back(rand_sample());
            sent += clampv(w, 1024) * clampv(h, 1024);
            if (phase == 5) hold_req = 1;
            settle();
            calm = 0;
            phase++;
        end

        $display("covered %0d samples in %0d images, %0d results checked", n_in,
                 phase + 4, n_out);
        $display("%0d results with zero kernel sum, %0d image ends", n_zero, n_last);
        if (errors == 0 && filt_due.size() == 0) begin
            $display("** normalized_2d_convolution: PASSED **");
        end else begin
            $display("%0d mismatches", errors);
            $display("** normalized_2d_convolution: FAILED **");
        end
        $finish;
    end
endmodule
